// ===== hdl/move_list_score_sort_assert.svh =====
// Assertion helpers for the sort RTL, used by mlss_core. Expect clk and arst_n in scope.
`ifndef MOVE_LIST_SCORE_SORT_ASSERT_SVH
`define MOVE_LIST_SCORE_SORT_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define MLSS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// ante in one cycle implies cons in the next
`define MLSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mlss_pkg.sv =====
package mlss_pkg;

	localparam int MAX_MOVES = 64;
	localparam int ADDR_W    = $clog2(MAX_MOVES);
	localparam int CNT_W     = $clog2(MAX_MOVES + 1);

	typedef struct packed {
		logic [5:0]         from_sq;
		logic [5:0]         to_sq;
		logic [15:0]        extra;
		logic signed [15:0] score;
	} record_t;

	typedef struct packed {
		record_t rec;
		logic    last;
		logic    ovf;
	} emit_t;

	// candidate unit control: load a fresh candidate or compare against it
	typedef struct packed {
		logic load;
		logic cmp;
	} cand_ctl_t;

endpackage

// ===== hdl/mlss_if.sv =====
interface mlss_in_if;
	logic               valid;
	logic               ready;
	logic [5:0]         from_square;
	logic [5:0]         to_square;
	logic [15:0]        extra_bits;
	logic signed [15:0] sort_score;
	logic               last_item;

	modport source (output valid, from_square, to_square, extra_bits, sort_score, last_item,
		input ready);
	modport sink (input valid, from_square, to_square, extra_bits, sort_score, last_item,
		output ready);
endinterface

interface mlss_out_if;
	logic               valid;
	logic               ready;
	logic [5:0]         out_from;
	logic [5:0]         out_to;
	logic [15:0]        out_extra;
	logic signed [15:0] out_score;
	logic               out_last;
	logic               overflow;

	modport source (output valid, out_from, out_to, out_extra, out_score, out_last, overflow,
		input ready);
	modport sink (input valid, out_from, out_to, out_extra, out_score, out_last, overflow,
		output ready);
endinterface

// ===== hdl/mlss_cand.sv =====
// Candidate register for the current sort position plus the one score comparator.
module mlss_cand import mlss_pkg::*; (
	input  logic      clk,
	input  cand_ctl_t ctl,
	input  record_t   rec,
	output record_t   cand,
	output logic      swap
);

	record_t cand_q;

	assign swap = ctl.cmp && ($signed(cand_q.score) < $signed(rec.score));
	assign cand = cand_q;

	always_ff @(posedge clk) begin
		if (ctl.load || swap) begin
			cand_q <= rec;
		end
	end

endmodule

// ===== hdl/mlss_core.sv =====
`include "move_list_score_sort_assert.svh"

// Record store and sort sequencer. Position i lives in the candidate register
// while j sweeps the later entries; a swap writes the old candidate back to j.
module mlss_core import mlss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  record_t in_rec,
	input  logic    in_last,
	output logic    emit_valid,
	output emit_t   emit_item,
	input  logic    emit_ready
);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              drop_q;
	logic [ADDR_W-1:0] i_q;
	logic [CNT_W-1:0]  j_q;
	logic              rdv_s1;
	logic [ADDR_W-1:0] rdidx_s1;

	record_t           mem [MAX_MOVES];
	record_t           rdata_s1;

	logic              accept;
	logic              full;
	logic              issue;
	logic              last_pos;
	logic              push;
	logic              we;
	logic [ADDR_W-1:0] wa;
	record_t           wd;
	cand_ctl_t         ctl;
	record_t           cand;
	logic              swap;

	mlss_cand u_cand (
		.clk  (clk),
		.ctl  (ctl),
		.rec  (rdata_s1),
		.cand (cand),
		.swap (swap)
	);

	always_comb begin
		in_ready   = (state_q == ST_LOAD);
		accept     = in_valid && in_ready;
		full       = (cnt_q == CNT_W'(MAX_MOVES));
		issue      = (state_q == ST_SCAN) && (j_q < cnt_q);
		ctl.load   = rdv_s1 && (rdidx_s1 == i_q);
		ctl.cmp    = rdv_s1 && (rdidx_s1 != i_q);
		last_pos   = ((CNT_W'(i_q) + CNT_W'(1)) == cnt_q);
		emit_valid = (state_q == ST_EMIT);
		emit_item  = '{rec: cand, last: last_pos, ovf: drop_q};
		push       = emit_valid && emit_ready;
		we         = (accept && !full) || swap;
		wa         = swap ? rdidx_s1 : cnt_q[ADDR_W-1:0];
		wd         = swap ? cand : in_rec;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_s1 <= mem[j_q[ADDR_W-1:0]];
		rdidx_s1 <= j_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			rdv_s1  <= 1'b0;
		end else begin
			rdv_s1 <= issue;
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (!full) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (in_last) begin
							state_q <= ST_SCAN;
							i_q     <= '0;
							j_q     <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						j_q <= j_q + CNT_W'(1);
					end else if (!rdv_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (push) begin
						if (last_pos) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							// first read of the next pass returns position i itself
							i_q     <= i_q + ADDR_W'(1);
							j_q     <= CNT_W'(i_q) + CNT_W'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	`MLSS_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNT_W'(MAX_MOVES), "record count past capacity")
	`MLSS_ASSERT_ALWAYS(a_rd_window, !rdv_s1 || ((rdidx_s1 >= i_q) && (CNT_W'(rdidx_s1) < cnt_q)), "scan read outside list")
	`MLSS_ASSERT_ALWAYS(a_swap_idx, !swap || (rdidx_s1 != i_q), "swap hit the current position")
	`MLSS_ASSERT_NEXT(a_list_clear, push && last_pos, (cnt_q == '0) && !drop_q, "list not cleared after run")

endmodule

// ===== hdl/mlss_out.sv =====
// Output register: holds one item so the sequencer can move on while it waits.
module mlss_out import mlss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  emit_valid,
	input  emit_t emit_item,
	output logic  emit_ready,
	mlss_out_if.source sorted
);

	emit_t item_q;
	logic  vld_q;

	assign emit_ready = !vld_q || sorted.ready;

	always_ff @(posedge clk) begin
		if (emit_valid && emit_ready) begin
			item_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (emit_valid && emit_ready) begin
			vld_q <= 1'b1;
		end else if (sorted.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_comb begin
		sorted.valid     = vld_q;
		sorted.out_from  = item_q.rec.from_sq;
		sorted.out_to    = item_q.rec.to_sq;
		sorted.out_extra = item_q.rec.extra;
		sorted.out_score = item_q.rec.score;
		sorted.out_last  = item_q.last;
		sorted.overflow  = item_q.ovf;
	end

endmodule

// ===== hdl/move_list_score_sort.sv =====
// channel  dir  fields
// moves    in   from_square, to_square, extra_bits, sort_score, last_item
// sorted   out  out_from, out_to, out_extra, out_score, out_last, overflow
//
// While loading, moves.ready is high and every valid item is taken; items past capacity are dropped.
// After the last item, each sorted position i is found by a scan that reads records
// i to n-1 in turn through the single read port of the record memory, for n records.
// moves.ready is low from the last item until the final record enters the output reg.
// Reset clears state, count, indices and flags only; the record store needs no clearing pass.
// A stall on sorted holds the sequencer at the current position.
module move_list_score_sort import mlss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mlss_in_if.sink    moves,
	mlss_out_if.source sorted
);

	record_t in_rec;
	logic    emit_valid;
	emit_t   emit_item;
	logic    emit_ready;
	logic    in_ready;

	assign in_rec = '{
		from_sq: moves.from_square,
		to_sq:   moves.to_square,
		extra:   moves.extra_bits,
		score:   moves.sort_score
	};
	assign moves.ready = in_ready;

	mlss_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (moves.valid),
		.in_ready   (in_ready),
		.in_rec     (in_rec),
		.in_last    (moves.last_item),
		.emit_valid (emit_valid),
		.emit_item  (emit_item),
		.emit_ready (emit_ready)
	);

	mlss_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit_valid (emit_valid),
		.emit_item  (emit_item),
		.emit_ready (emit_ready),
		.sorted     (sorted)
	);

endmodule
